// ===== design/tlca_pkg.sv =====
`timescale 1ns / 1ps

package tlca_pkg;

  // Fixed field widths of the stream payload
  localparam int FIELD_W = 10;
  localparam int DEPTH_W = 11;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [DEPTH_W-1:0] depth_t;

  localparam depth_t DEPTH_MAX  = 11'd2047;
  localparam depth_t DEPTH_ROOT = 11'd1;
  localparam field_t FIELD_MAX  = 10'd1023;

  // Item kinds carried on tuser
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

endpackage

// ===== design/tree_lca_distance_binary_lifting.sv =====
`timescale 1ns / 1ps

// Pacing: a root load writes its levels in turn, another load reads and writes each level
//   in turn, and a query may also wait on output stalls; all are set by the single
//   ancestor-table read port and the shared node*LEVELS+level address unit.
// Throughput: one transaction at a time; in_tready is high only while the sequencer idles.
// Reset: synchronous, active low; a clearing pass zeroes every entry of the depth store,
//   and no input transaction is taken until it ends. The ancestor table is not cleared.
module tree_lca_distance_binary_lifting #(
  parameter int NODES  = 1024,
  parameter int LEVELS = 11
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [9:0] node, [19:10] other, [23:20] zero
  input  logic        in_tuser,   // [0] kind
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [9:0] ancestor, [19:10] distance, [23:20] zero
);

  localparam int NW  = $clog2(NODES);
  localparam int LW  = $clog2(LEVELS);
  localparam int AAW = $clog2(NODES * LEVELS);
  localparam logic [LW-1:0] LVL_LAST = LW'(LEVELS - 1);
  localparam logic [NW-1:0] CLR_LAST = NW'(NODES - 1);
  localparam int DEPTH_W_SUM = tlca_pkg::DEPTH_W;

  // Sequencer codes
  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_RT_WR  = 5'd2;
  localparam logic [4:0] S_LD_DRD = 5'd3;
  localparam logic [4:0] S_LD_DEP = 5'd4;
  localparam logic [4:0] S_LD_RD  = 5'd5;
  localparam logic [4:0] S_LD_WR  = 5'd6;
  localparam logic [4:0] S_Q_D1   = 5'd7;
  localparam logic [4:0] S_Q_D2   = 5'd8;
  localparam logic [4:0] S_Q_D3   = 5'd9;
  localparam logic [4:0] S_Q_LIFT = 5'd10;
  localparam logic [4:0] S_Q_LIFW = 5'd11;
  localparam logic [4:0] S_Q_CHK  = 5'd12;
  localparam logic [4:0] S_Q_CLA  = 5'd13;
  localparam logic [4:0] S_Q_CLB  = 5'd14;
  localparam logic [4:0] S_Q_CLC  = 5'd15;
  localparam logic [4:0] S_Q_FIN  = 5'd16;
  localparam logic [4:0] S_Q_FINW = 5'd17;
  localparam logic [4:0] S_Q_LD   = 5'd18;
  localparam logic [4:0] S_Q_LDW  = 5'd19;
  localparam logic [4:0] S_Q_OUT  = 5'd20;

  // Input payload split
  tlca_pkg::field_t in_node, in_other;
  logic             node_ok, other_ok;

  assign in_node  = in_tdata[9:0];
  assign in_other = in_tdata[19:10];
  assign node_ok  = (32'(in_node) < NODES);
  assign other_ok = (32'(in_other) < NODES);

  // Control and working registers
  logic [4:0]    state_r, state_nxt;
  logic [NW-1:0] clr_r, clr_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;

  logic [NW-1:0]       x_r, x_nxt;      // loaded node / first climbing node / result
  logic [NW-1:0]       y_r, y_nxt;      // parent and running ancestor / second node
  logic [NW-1:0]       ax_r, ax_nxt;    // ancestor of x at the current climb level
  tlca_pkg::depth_t    da_r, da_nxt;    // depth of the first query node
  tlca_pkg::depth_t    dif_r, dif_nxt;  // remaining lift, shifted one level a step
  logic [DEPTH_W_SUM:0] dsum_r, dsum_nxt;
  tlca_pkg::field_t    res_anc_r, res_anc_nxt;
  tlca_pkg::field_t    res_dist_r, res_dist_nxt;
  logic [23:0]         out_tdata_r, out_tdata_nxt;

  // Memory ports
  logic [NW-1:0]    anode_c;
  logic [LW-1:0]    alvl_c;
  logic [AAW-1:0]   addr_c;
  logic             awe_c;
  logic [NW-1:0]    awd_c;
  logic [NW-1:0]    q_r;

  logic [NW-1:0]    dra_c, dwa_c;
  logic             dwe_c;
  tlca_pkg::depth_t dwd_c;
  tlca_pkg::depth_t dq_r;

  // Lift step bookkeeping
  logic lift_last;
  logic signed [DEPTH_W_SUM+1:0] dist_c;

  logic [NW-1:0]          amem [NODES*LEVELS];
  tlca_pkg::depth_t       dmem [NODES];

  // Shared address unit: node * LEVELS + level, used by every table access
  assign addr_c = AAW'(AAW'(anode_c) * AAW'(LEVELS) + AAW'(alvl_c));

  // Ancestor table: one write, one registered read per cycle at the shared address
  always_ff @(posedge clk) begin
    if (awe_c) begin
      amem[addr_c] <= awd_c;
    end
    q_r <= amem[addr_c];
  end

  // Depth store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (dwe_c) begin
      dmem[dwa_c] <= dwd_c;
    end
    dq_r <= dmem[dra_c];
  end

  assign lift_last = (lvl_r == LVL_LAST) || (dif_r[tlca_pkg::DEPTH_W-1:1] == '0);
  assign dist_c = $signed({1'b0, dsum_r}) - $signed({1'b0, dq_r, 1'b0});

  // Table address and write selection by step
  always_comb begin
    anode_c = x_r;
    alvl_c  = lvl_r;
    awe_c   = 1'b0;
    awd_c   = x_r;
    unique case (state_r)
      S_RT_WR: begin
        awe_c = 1'b1;
      end
      S_LD_DEP: begin
        alvl_c = '0;
        awe_c  = 1'b1;
        awd_c  = y_r;
      end
      S_LD_RD: begin
        anode_c = y_r;
        alvl_c  = lvl_r - 1'b1;
      end
      S_LD_WR: begin
        awe_c = 1'b1;
        awd_c = q_r;
      end
      S_Q_CLB: begin
        anode_c = y_r;
      end
      S_Q_FIN: begin
        alvl_c = '0;
      end
      default: begin
      end
    endcase
  end

  // Depth store address and write selection
  always_comb begin
    dra_c = x_r;
    dwa_c = x_r;
    dwe_c = 1'b0;
    dwd_c = tlca_pkg::DEPTH_ROOT;
    unique case (state_r) inside
      S_CLR: begin
        dwa_c = clr_r;
        dwe_c = 1'b1;
        dwd_c = '0;
      end
      S_RT_WR: begin
        dwe_c = 1'b1;
      end
      S_LD_DRD, S_Q_D2: begin
        dra_c = y_r;
      end
      S_LD_DEP: begin
        dwe_c = 1'b1;
        // saturate the depth at its field maximum
        dwd_c = (dq_r == tlca_pkg::DEPTH_MAX) ? tlca_pkg::DEPTH_MAX : dq_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    lvl_nxt        = lvl_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    ax_nxt         = ax_r;
    da_nxt         = da_r;
    dif_nxt        = dif_r;
    dsum_nxt       = dsum_r;
    res_anc_nxt    = res_anc_r;
    res_dist_nxt   = res_dist_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    in_tready      = (state_r == S_IDLE);

    unique case (state_r) inside
      S_CLR: begin
        // zero one depth entry a cycle
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          x_nxt   = NW'(in_node);
          y_nxt   = NW'(in_other);
          lvl_nxt = '0;
          if (in_tuser == tlca_pkg::KIND_LOAD) begin
            // drop loads that name a node beyond the store
            if (node_ok && other_ok) begin
              state_nxt = (in_node == in_other) ? S_RT_WR : S_LD_DRD;
            end
          end else begin
            if (node_ok && other_ok) begin
              state_nxt = S_Q_D1;
            end else begin
              res_anc_nxt  = '0;
              res_dist_nxt = '0;
              state_nxt    = S_Q_OUT;
            end
          end
        end
      end
      S_RT_WR: begin
        // root: every level points to itself
        lvl_nxt = lvl_r + 1'b1;
        if (lvl_r == LVL_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_LD_DRD: begin
        state_nxt = S_LD_DEP;
      end
      S_LD_DEP: begin
        lvl_nxt   = LW'(1);
        state_nxt = S_LD_RD;
      end
      S_LD_RD: begin
        state_nxt = S_LD_WR;
      end
      S_LD_WR: begin
        // level i is level i-1 of the level i-1 ancestor
        y_nxt = q_r;
        if (lvl_r == LVL_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          lvl_nxt   = lvl_r + 1'b1;
          state_nxt = S_LD_RD;
        end
      end
      S_Q_D1: begin
        state_nxt = S_Q_D2;
      end
      S_Q_D2: begin
        da_nxt    = dq_r;
        state_nxt = S_Q_D3;
      end
      S_Q_D3: begin
        // keep the deeper node in x
        dsum_nxt = {1'b0, da_r} + {1'b0, dq_r};
        lvl_nxt  = '0;
        if (da_r < dq_r) begin
          x_nxt   = y_r;
          y_nxt   = x_r;
          dif_nxt = dq_r - da_r;
        end else begin
          dif_nxt = da_r - dq_r;
        end
        state_nxt = S_Q_LIFT;
      end
      S_Q_LIFT, S_Q_LIFW: begin
        if (state_r == S_Q_LIFW) begin
          x_nxt = q_r;
        end
        if (state_r == S_Q_LIFT && dif_r[0]) begin
          state_nxt = S_Q_LIFW;
        end else if (lift_last) begin
          state_nxt = S_Q_CHK;
        end else begin
          lvl_nxt   = lvl_r + 1'b1;
          dif_nxt   = dif_r >> 1;
          state_nxt = S_Q_LIFT;
        end
      end
      S_Q_CHK: begin
        if (x_r == y_r) begin
          state_nxt = S_Q_LD;
        end else begin
          lvl_nxt   = LVL_LAST;
          state_nxt = S_Q_CLA;
        end
      end
      S_Q_CLA: begin
        state_nxt = S_Q_CLB;
      end
      S_Q_CLB: begin
        ax_nxt    = q_r;
        state_nxt = S_Q_CLC;
      end
      S_Q_CLC: begin
        // climb both while their ancestors differ
        if (ax_r != q_r) begin
          x_nxt = ax_r;
          y_nxt = q_r;
        end
        if (lvl_r == '0) begin
          state_nxt = S_Q_FIN;
        end else begin
          lvl_nxt   = lvl_r - 1'b1;
          state_nxt = S_Q_CLA;
        end
      end
      S_Q_FIN: begin
        state_nxt = S_Q_FINW;
      end
      S_Q_FINW: begin
        x_nxt     = q_r;
        state_nxt = S_Q_LD;
      end
      S_Q_LD: begin
        state_nxt = S_Q_LDW;
      end
      S_Q_LDW: begin
        res_anc_nxt = tlca_pkg::FIELD_W'(x_r);
        if (dist_c < 0) begin
          res_dist_nxt = '0;
        end else if (dist_c > $signed({3'b000, tlca_pkg::FIELD_MAX})) begin
          res_dist_nxt = tlca_pkg::FIELD_MAX;
        end else begin
          res_dist_nxt = dist_c[tlca_pkg::FIELD_W-1:0];
        end
        state_nxt = S_Q_OUT;
      end
      S_Q_OUT: begin
        // hold until the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_tdata_nxt  = {4'b0000, res_dist_r, res_anc_r};
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_r        <= '0;
      lvl_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      lvl_r        <= lvl_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    ax_r        <= ax_nxt;
    da_r        <= da_nxt;
    dif_r       <= dif_nxt;
    dsum_r      <= dsum_nxt;
    res_anc_r   <= res_anc_nxt;
    res_dist_r  <= res_dist_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
